// ===== rtl/mqc_pkg.sv =====
// Shared types and constants for the mod-q coefficient pack codec.
`timescale 1ns / 1ps

package mqc_pkg;

  localparam int MODULUS_DEFAULT = 3457;
  localparam int BARRETT_MUL     = 9;
  localparam int FIELD_BITS      = 12;
  localparam int LANES           = 4;
  localparam int COEF_BITS       = 16;
  localparam int WIRE_BITS       = FIELD_BITS * LANES;

  localparam logic [FIELD_BITS-1:0] FIELD_MASK = 12'h0FFF;

  typedef enum logic [1:0] {
    OP_ENC_FULL  = 2'd0,
    OP_ENC_CANON = 2'd1,
    OP_DECODE    = 2'd2,
    OP_COMPARE   = 2'd3
  } op_t;

  // One input transaction, unpacked.
  typedef struct packed {
    op_t                                  opcode;
    logic [LANES-1:0][COEF_BITS-1:0]      coef;
    logic [WIRE_BITS-1:0]                 wire_in;
    logic                                 last_block;
  } in_item_t;

  // One result transaction.
  typedef struct packed {
    logic [WIRE_BITS-1:0]                 wire_out;
    logic [LANES-1:0][FIELD_BITS-1:0]     dec;
    logic                                 range_error;
    logic                                 mismatch;
    logic                                 last_out;
  } res_item_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic load_in;
    logic load_quot;
    logic load_out;
  } mqc_cmd_t;

endpackage

// ===== rtl/mqc_datapath.sv =====
// Datapath: input capture, per-lane quotient estimate, reduce/pack/decode, sticky flags.
`timescale 1ns / 1ps

module mqc_datapath import mqc_pkg::*; #(
  parameter int MODULUS = MODULUS_DEFAULT
) (
  input  logic      clk,
  input  logic      rst,
  input  mqc_cmd_t  cmd,
  input  in_item_t  in_item,
  output res_item_t res_item
);

  localparam logic signed [21:0] MUL2    = 22'(2 * BARRETT_MUL);
  localparam logic signed [21:0] ROUND   = 22'sd32768;
  localparam logic signed [17:0] MOD_S   = 18'(MODULUS);
  localparam logic [COEF_BITS-1:0] MOD16 = COEF_BITS'(MODULUS);
  localparam logic [FIELD_BITS-1:0] MOD12 = FIELD_BITS'(MODULUS);

  // Captured item
  op_t                                   op_q;
  logic signed [LANES-1:0][COEF_BITS-1:0] coef_q;
  logic [WIRE_BITS-1:0]                  wire_q;
  logic                                  last_q;

  // Rounded quotient estimate per lane, range -9..9
  logic signed [4:0] quot [LANES];
  logic signed [4:0] quot_next [LANES];
  logic signed [21:0] scaled [LANES];

  logic [COEF_BITS-1:0] red_full [LANES];
  logic [COEF_BITS-1:0] red_canon [LANES];
  logic [COEF_BITS-1:0] canon_v [LANES];
  logic signed [17:0] diff [LANES];
  logic [WIRE_BITS-1:0] pack_full;
  logic [WIRE_BITS-1:0] pack_canon;
  logic [LANES-1:0] field_big;

  logic range_sticky;
  logic mismatch_sticky;
  res_item_t res_next;

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      scaled[i]    = 22'(signed'(coef_q[i])) * MUL2 + ROUND;
      quot_next[i] = scaled[i][20:16];
    end
  end

  always_comb begin
    pack_full  = '0;
    pack_canon = '0;
    for (int i = 0; i < LANES; i++) begin
      diff[i]     = 18'(signed'(coef_q[i])) - 18'(quot[i]) * MOD_S;
      red_full[i] = diff[i][COEF_BITS-1:0];
      if (red_full[i][COEF_BITS-1]) begin
        red_full[i] = red_full[i] + MOD16;
      end
      canon_v[i]   = coef_q[i] + MOD16;
      red_canon[i] = (coef_q[i] < canon_v[i]) ? coef_q[i] : canon_v[i];
      pack_full[i*FIELD_BITS +: FIELD_BITS]  = red_full[i][FIELD_BITS-1:0] & FIELD_MASK;
      pack_canon[i*FIELD_BITS +: FIELD_BITS] = red_canon[i][FIELD_BITS-1:0] & FIELD_MASK;
      field_big[i] = (wire_q[i*FIELD_BITS +: FIELD_BITS] >= MOD12);
    end
  end

  always_comb begin
    res_next             = '0;
    res_next.last_out    = last_q;
    res_next.range_error = range_sticky;
    res_next.mismatch    = mismatch_sticky;
    unique case (op_q)
      OP_ENC_FULL:  res_next.wire_out = pack_full;
      OP_ENC_CANON: res_next.wire_out = pack_canon;
      OP_DECODE: begin
        for (int i = 0; i < LANES; i++) begin
          res_next.dec[i] = wire_q[i*FIELD_BITS +: FIELD_BITS];
        end
        res_next.range_error = range_sticky | (|field_big);
      end
      OP_COMPARE: begin
        res_next.wire_out = pack_full ^ wire_q;
        res_next.mismatch = mismatch_sticky | (|(pack_full ^ wire_q));
      end
      default: res_next.wire_out = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op_q   <= in_item.opcode;
      coef_q <= in_item.coef;
      wire_q <= in_item.wire_in;
      last_q <= in_item.last_block;
    end
    if (cmd.load_quot) begin
      for (int i = 0; i < LANES; i++) begin
        quot[i] <= quot_next[i];
      end
    end
    if (cmd.load_out) begin
      res_item <= res_next;
    end
  end

  // Flags cover one polynomial; cleared once the last block is reported.
  always_ff @(posedge clk) begin
    if (rst) begin
      range_sticky    <= 1'b0;
      mismatch_sticky <= 1'b0;
    end else if (cmd.load_out) begin
      range_sticky    <= last_q ? 1'b0 : res_next.range_error;
      mismatch_sticky <= last_q ? 1'b0 : res_next.mismatch;
    end
  end

endmodule

// ===== rtl/mqc_ctrl.sv =====
// Controller: sequences capture, quotient and result stages and owns both handshakes.
`timescale 1ns / 1ps

module mqc_ctrl import mqc_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  output mqc_cmd_t cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_QUOT,
    ST_EMIT
  } state_t;

  state_t state;
  logic   out_free;

  assign in_ready = (state == ST_IDLE);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    cmd           = '0;
    cmd.load_in   = (state == ST_IDLE) && in_valid;
    cmd.load_quot = (state == ST_QUOT);
    cmd.load_out  = (state == ST_EMIT) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: if (in_valid) state <= ST_QUOT;
        ST_QUOT: state <= ST_EMIT;
        ST_EMIT: if (out_free) state <= ST_IDLE;
        default: state <= ST_IDLE;
      endcase
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // a pending result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!out_valid || out_ready))
    else $error("result register overwritten while held");

  a_accept_seq: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == ST_QUOT))
    else $error("accepted transaction did not start quotient stage");

  a_valid_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(cmd.load_out))
    else $error("output valid raised without a result load");

  a_one_step: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load_in, cmd.load_quot, cmd.load_out}))
    else $error("more than one stage command at once");

endmodule

// ===== rtl/mod_q_coefficient_pack_codec_unit.sv =====
// Top level of the mod-q 12-bit coefficient pack codec.
`timescale 1ns / 1ps

// Packs four signed coefficients into a 48-bit wire word (q-reduced or canonicalized),
// unpacks a wire word into four 12-bit fields, or compares an encoded block against an
// expected word. One result per input transaction. Each transaction runs three steps:
// capture, rounded quotient estimate per lane (registered after the constant multiply),
// then reduce/pack/decode into the output register. A new transaction is taken while a
// finished result still waits in the output register, but not before the last one has
// been through all three steps. range_error and mismatch are sticky over one polynomial
// and clear after the result that carries last set.
module mod_q_coefficient_pack_codec_unit import mqc_pkg::*; #(
  parameter int MODULUS = MODULUS_DEFAULT
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [111:0] s_tdata,  // coef_a, coef_b, coef_c, coef_d, wire_in
  input  logic [1:0]   s_tuser,  // opcode
  input  logic         s_tlast,
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [103:0] m_tdata,  // wire_out, dec_a, dec_b, dec_c, dec_d, range_error,
                                 // mismatch, 6 zero bits
  output logic         m_tlast
);

  mqc_cmd_t  cmd;
  in_item_t  in_item;
  res_item_t res_item;

  always_comb begin
    in_item.opcode     = op_t'(s_tuser);
    for (int i = 0; i < LANES; i++) begin
      in_item.coef[i] = s_tdata[i*COEF_BITS +: COEF_BITS];
    end
    in_item.wire_in    = s_tdata[LANES*COEF_BITS +: WIRE_BITS];
    in_item.last_block = s_tlast;
  end

  mqc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .cmd       (cmd)
  );

  mqc_datapath #(
    .MODULUS (MODULUS)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .in_item  (in_item),
    .res_item (res_item)
  );

  always_comb begin
    m_tdata = '0;
    m_tdata[WIRE_BITS-1:0] = res_item.wire_out;
    for (int i = 0; i < LANES; i++) begin
      m_tdata[WIRE_BITS + i*FIELD_BITS +: FIELD_BITS] = res_item.dec[i];
    end
    m_tdata[2*WIRE_BITS]     = res_item.range_error;
    m_tdata[2*WIRE_BITS + 1] = res_item.mismatch;
  end

  assign m_tlast = res_item.last_out;

endmodule

// ===== tb/tb_mod_q_coefficient_pack_codec_unit.sv =====
// Self-checking testbench for the mod-q 12-bit coefficient pack codec.
`timescale 1ns / 1ps

module tb_mod_q_coefficient_pack_codec_unit;
  import mqc_pkg::*;

  localparam int Q = MODULUS_DEFAULT;
  localparam int RANDOM_BLOCKS = 1800;

  // Predicts each result block and holds the ones still in flight.
  class pack_codec_checker;
    bit range_sticky;
    bit mismatch_sticky;
    res_item_t pending_blocks[$];
    int errors;

    // Rounding multiply by 18 and shift right by 16, subtract t*q, then fold negatives back by q.
    function logic [15:0] barrett_lane(logic signed [15:0] a);
      int p;
      int t;
      logic [15:0] r;
      p = 18 * int'(a) + 32768;
      t = p >>> 16;
      r = 16'(int'(a) - t * Q);
      if (r[15]) r = r + 16'(Q);
      return r;
    endfunction

    function logic [15:0] canon_lane(logic [15:0] a);
      logic [15:0] v;
      v = a + 16'(Q);
      return (a < v) ? a : v;
    endfunction

    function logic [47:0] reduce_and_pack(op_t op, logic [3:0][15:0] coef);
      logic [47:0] w;
      logic [15:0] r;
      w = '0;
      for (int i = 0; i < 4; i++) begin
        r = (op == OP_ENC_CANON) ? canon_lane(coef[i]) : barrett_lane(coef[i]);
        w[12*i +: 12] = r[11:0];
      end
      return w;
    endfunction

    function void log_block(in_item_t it);
      res_item_t e;
      e = '0;
      if (it.opcode == OP_DECODE) begin
        for (int i = 0; i < 4; i++) begin
          e.dec[i] = it.wire_in[12*i +: 12];
          if (e.dec[i] >= 12'(Q)) range_sticky = 1'b1;
        end
      end else begin
        e.wire_out = reduce_and_pack(it.opcode, it.coef);
        if (it.opcode == OP_COMPARE) begin
          e.wire_out = e.wire_out ^ it.wire_in;
          if (e.wire_out != '0) mismatch_sticky = 1'b1;
        end
      end
      e.range_error = range_sticky;
      e.mismatch = mismatch_sticky;
      e.last_out = it.last_block;
      if (it.last_block) begin
        range_sticky = 1'b0;
        mismatch_sticky = 1'b0;
      end
      pending_blocks.push_back(e);
    endfunction

    function void check_block(res_item_t got);
      res_item_t e;
      if (pending_blocks.size() == 0) begin
        $display("%0t: result with nothing expected, actual %h", $time, got);
        errors++;
        return;
      end
      e = pending_blocks.pop_front();
      if (got.wire_out !== e.wire_out) begin
        $display("%0t: wire_out expected %h actual %h", $time, e.wire_out, got.wire_out);
        errors++;
      end
      for (int i = 0; i < 4; i++)
        if (got.dec[i] !== e.dec[i]) begin
          $display("%0t: dec[%0d] expected %h actual %h", $time, i, e.dec[i], got.dec[i]);
          errors++;
        end
      if (got.range_error !== e.range_error) begin
        $display("%0t: range_error expected %b actual %b", $time, e.range_error,
                 got.range_error);
        errors++;
      end
      if (got.mismatch !== e.mismatch) begin
        $display("%0t: mismatch expected %b actual %b", $time, e.mismatch, got.mismatch);
        errors++;
      end
      if (got.last_out !== e.last_out) begin
        $display("%0t: last_out expected %b actual %b", $time, e.last_out, got.last_out);
        errors++;
      end
    endfunction
  endclass

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [111:0] s_tdata = '0;
  logic [1:0]   s_tuser = '0;
  logic         s_tlast = 1'b0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [103:0] m_tdata;
  logic         m_tlast;

  pack_codec_checker sb = new;
  int blocks_sent = 0;
  int burst_left = 0;
  bit hold_done = 1'b0;

  mod_q_coefficient_pack_codec_unit DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always #4 clk = ~clk;

  initial begin
    #5ms;
    $display("tb: failure");
    $finish;
  end

  // Result monitor.
  always @(posedge clk) begin
    res_item_t got;
    if (!rst && m_tvalid && m_tready) begin
      got.wire_out = m_tdata[47:0];
      for (int i = 0; i < 4; i++) got.dec[i] = m_tdata[48 + 12*i +: 12];
      got.range_error = m_tdata[96];
      got.mismatch = m_tdata[97];
      got.last_out = m_tlast;
      sb.check_block(got);
    end
  end

  // Sink: stall patterns switched at random, plus one long hold-off so the pipe backs up.
  initial begin
    int cyc;
    int pattern;
    cyc = 0;
    forever begin
      @(negedge clk);
      cyc++;
      if (cyc % 97 == 0) pattern = $urandom_range(0, 3);
      if (!hold_done && blocks_sent >= 700) begin
        hold_done = 1'b1;
        m_tready <= 1'b0;
        repeat (399) begin
          @(negedge clk);
          m_tready <= 1'b0;
        end
      end else begin
        case (pattern)
          0: m_tready <= 1'b1;
          1: m_tready <= 1'($urandom_range(0, 1));
          2: m_tready <= (cyc % 4 == 0);
          default: m_tready <= ($urandom_range(0, 9) < 8);
        endcase
      end
    end
  end

  function automatic in_item_t make_block(op_t op, int a, int b, int c, int d,
                                          logic [47:0] wire_word, bit last);
    in_item_t it;
    it.opcode = op;
    it.coef[0] = 16'(a);
    it.coef[1] = 16'(b);
    it.coef[2] = 16'(c);
    it.coef[3] = 16'(d);
    it.wire_in = wire_word;
    it.last_block = last;
    return it;
  endfunction

  function automatic logic [47:0] rand_wire();
    return {16'($urandom), $urandom};
  endfunction

  function automatic int rand_coef();
    case ($urandom_range(0, 3))
      0: return int'($urandom_range(0, 65535)) - 32768;
      1: return int'($urandom_range(0, 8000)) - 4000;
      2: return (int'($urandom_range(0, 18)) - 9) * Q + int'($urandom_range(0, 4)) - 2;
      default: begin
        case ($urandom_range(0, 3))
          0: return -32768;
          1: return 32767;
          2: return -1;
          default: return 0;
        endcase
      end
    endcase
  endfunction

  task automatic send_block(in_item_t it);
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata <= {it.wire_in, it.coef};
    s_tuser <= it.opcode;
    s_tlast <= it.last_block;
    do @(posedge clk); while (!s_tready);
    sb.log_block(it);
    blocks_sent++;
  endtask

  // Burst/gap pacing between transactions.
  task automatic pace();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 3) == 0 ? 60 : $urandom_range(1, 20);
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        @(negedge clk);
        s_tvalid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
  endtask

  task automatic drive(in_item_t it);
    send_block(it);
    pace();
  endtask

  task automatic random_polynomial();
    int len;
    int kind;
    op_t op;
    in_item_t it;
    logic [47:0] w;
    len = $urandom_range(1, 12);
    kind = $urandom_range(0, 4);
    for (int k = 0; k < len; k++) begin
      op = (kind == 4) ? op_t'($urandom_range(0, 3)) : op_t'(kind);
      it = make_block(op, rand_coef(), rand_coef(), rand_coef(), rand_coef(), rand_wire(),
                      k == len - 1);
      if (op == OP_COMPARE && $urandom_range(0, 99) < 85) begin
        it.wire_in = sb.reduce_and_pack(OP_ENC_FULL, it.coef);
        if ($urandom_range(0, 4) == 0) it.wire_in[$urandom_range(0, 47)] ^= 1'b1;
      end
      if (op == OP_DECODE && $urandom_range(0, 99) < 80) begin
        for (int i = 0; i < 4; i++) w[12*i +: 12] = 12'($urandom_range(0, Q - 1));
        it.wire_in = w;
      end
      // occasional stray bits on the last flag
      if ($urandom_range(0, 49) == 0) it.last_block = ~it.last_block;
      drive(it);
    end
  endtask

  initial begin
    in_item_t it;
    repeat (11) @(negedge clk);
    rst <= 1'b0;

    drive(make_block(OP_ENC_FULL, -32768, 32767, 0, -1, '0, 1'b0));
    drive(make_block(OP_ENC_FULL, Q - 1, Q, -Q, -Q - 1, '1, 1'b0));
    drive(make_block(OP_ENC_FULL, 16384, -16384, 1728, -1729, '0, 1'b1));
    drive(make_block(OP_ENC_CANON, -32768, 32767, 0, -1, '0, 1'b0));
    drive(make_block(OP_ENC_CANON, Q - 1, Q, -Q, -Q - 1, '1, 1'b1));
    drive(make_block(OP_DECODE, 0, 0, 0, 0, 48'h0, 1'b0));
    drive(make_block(OP_DECODE, -1, -1, -1, -1, {12'd0, 12'(Q - 1), 12'(Q - 1), 12'd0},
                     1'b0));
    drive(make_block(OP_DECODE, 0, 0, 0, 0, {12'hFFF, 12'(Q), 12'(Q - 1), 12'd0}, 1'b0));
    drive(make_block(OP_ENC_FULL, 1, 2, 3, 4, '0, 1'b1));
    it = make_block(OP_COMPARE, -1, 1, 1729, -1729, '0, 1'b0);
    it.wire_in = sb.reduce_and_pack(OP_ENC_FULL, it.coef);
    drive(it);
    it.wire_in[47] = ~it.wire_in[47];
    drive(it);
    drive(make_block(OP_DECODE, 0, 0, 0, 0, 48'hFFFF_FFFF_FFFF, 1'b1));
    drive(make_block(OP_ENC_CANON, 0, 0, 0, 0, '0, 1'b1));
    it = make_block(OP_COMPARE, -32768, 32767, Q, -Q, '0, 1'b1);
    it.wire_in = sb.reduce_and_pack(OP_ENC_FULL, it.coef) ^ 48'h1;
    drive(it);
    it = make_block(OP_COMPARE, -32768, 32767, Q, -Q, '0, 1'b1);
    it.wire_in = sb.reduce_and_pack(OP_ENC_FULL, it.coef);
    drive(it);
    drive(make_block(OP_DECODE, 0, 0, 0, 0, 48'hAAAA_AAAA_AAAA, 1'b0));
    drive(make_block(OP_DECODE, 0, 0, 0, 0, 48'h5555_5555_5555, 1'b1));

    while (blocks_sent < RANDOM_BLOCKS + 17) random_polynomial();

    @(negedge clk);
    s_tvalid <= 1'b0;
    while (sb.pending_blocks.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.pending_blocks.size() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
